/* rtl/rdm_pkg.sv */
package rdm_pkg;

    localparam int MAX_GEARS      = 8;
    localparam int GEARS_PER_WORD = 4;
    localparam int GIDX_W         = $clog2(MAX_GEARS);

    localparam int MPH_W   = 8;
    localparam int RPM_W   = 14;
    localparam int GEAR_W  = 4;
    localparam int RATIO_W = 16;
    localparam int FD_W    = 16;
    localparam int CIRC_W  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int MPH_FD_W   = MPH_W + FD_W;
    localparam int P_W        = RPM_W + CIRC_W;
    localparam int MID_W      = RATIO_W + 1;
    localparam int MID_PROD_W = MID_W + MPH_FD_W;
    localparam int REV_W      = 11;
    localparam int CMP_W      = MID_PROD_W + REV_W;
    localparam int LHS_SHIFT  = 17;
    localparam int REV_SH_HI  = 10;
    localparam int REV_SH_LO  = 5;
    localparam int TGT_PROD_W = MPH_FD_W + RATIO_W;
    localparam int NUM_SHIFT  = 16;
    localparam int DIVD_W     = TGT_PROD_W + REV_W - NUM_SHIFT;
    localparam int REM_W      = CIRC_W + RPM_W;

    localparam int S_TDATA_W = ((MPH_W + RPM_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((GEAR_W + RPM_W + 1 + 7) / 8) * 8;

    localparam logic [FD_W-1:0]   FD_RESET   = 16'd16384;
    localparam logic [CIRC_W-1:0] CIRC_RESET = 16'd20480;
    localparam logic [RPM_W-1:0]  MIN_RESET  = '0;
    localparam logic [RPM_W-1:0]  MAX_RESET  = '1;
    localparam logic [GEAR_W-1:0] GC_RESET   = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FINAL_DRIVE  = 3'd0,
        CFG_CIRCUMFERENCE = 3'd1,
        CFG_MIN_RPM      = 3'd2,
        CFG_MAX_RPM      = 3'd3,
        CFG_GEAR_COUNT   = 3'd4,
        CFG_RATIOS_LOW   = 3'd5,
        CFG_RATIOS_HIGH  = 3'd6
    } cfg_idx_t;

    typedef logic [MAX_GEARS-1:0][RATIO_W-1:0] ratio_set_t;

    typedef struct packed {
        logic [FD_W-1:0]   final_drive;
        logic [CIRC_W-1:0] circ;
        logic [RPM_W-1:0]  min_rpm;
        logic [RPM_W-1:0]  max_rpm;
        logic [GEAR_W-1:0] gear_count;
        ratio_set_t        ratios;
    } cfg_t;

    typedef struct packed {
        logic [GEAR_W-1:0]   gear;
        logic [MPH_FD_W-1:0] mph_fd;
    } est_t;

    typedef struct packed {
        logic [GEAR_W-1:0] gear;
        logic              ok;
        logic [REM_W-1:0]  rem;
        logic [RPM_W-1:0]  quo;
    } div_t;

    function automatic logic [GEAR_W-1:0] gears_in_use(input logic [GEAR_W-1:0] count);
        logic [GEAR_W-1:0] n;
        n = count;
        if (count == '0)
        begin
            n = GEAR_W'(1);
        end
        else if (count > GEAR_W'(MAX_GEARS))
        begin
            n = GEAR_W'(MAX_GEARS);
        end
        return n;
    endfunction

    // times 1056 = 2^10 + 2^5
    function automatic logic [CMP_W-1:0] rev_scale(input logic [MID_PROD_W-1:0] x);
        return (CMP_W'(x) << REV_SH_HI) + (CMP_W'(x) << REV_SH_LO);
    endfunction

endpackage

/* rtl/rdm_gear_est.sv */
module rdm_gear_est
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rdm_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rdm_pkg::MPH_W-1:0]     in_mph,
    input  logic [rdm_pkg::RPM_W-1:0]     in_rpm,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rdm_pkg::est_t                 out_data
);

    localparam int NMID = rdm_pkg::MAX_GEARS - 1;

    logic a_v_reg, b_v_reg, c_v_reg;
    logic a_rdy, b_rdy, c_rdy;

    logic [rdm_pkg::P_W-1:0]      a_p_reg, a_p_next, b_p_reg;
    logic [rdm_pkg::MPH_FD_W-1:0] a_m_reg, a_m_next, b_m_reg;
    logic                         a_mz_reg, a_mz_next, b_mz_reg;

    logic [rdm_pkg::MID_PROD_W-1:0] b_mp_reg  [NMID];
    logic [rdm_pkg::MID_PROD_W-1:0] b_mp_next [NMID];

    rdm_pkg::est_t c_reg, c_next;

    logic [rdm_pkg::CMP_W-1:0] lhs;
    logic [NMID-1:0]           gt;
    logic [rdm_pkg::GEAR_W-1:0] n_gears;

    assign c_rdy    = !c_v_reg || out_ready;
    assign b_rdy    = !b_v_reg || c_rdy;
    assign a_rdy    = !a_v_reg || b_rdy;
    assign in_ready = a_rdy;

    assign out_valid = c_v_reg;
    assign out_data  = c_reg;

    always_comb
    begin
        a_p_next  = rdm_pkg::P_W'(in_rpm) * rdm_pkg::P_W'(cfg.circ);
        a_m_next  = rdm_pkg::MPH_FD_W'(in_mph) * rdm_pkg::MPH_FD_W'(cfg.final_drive);
        a_mz_next = (in_mph == '0);
    end

    always_comb
    begin
        for (int i = 0; i < NMID; i++)
        begin
            b_mp_next[i] = rdm_pkg::MID_PROD_W'(rdm_pkg::MID_W'(cfg.ratios[i])
                           + rdm_pkg::MID_W'(cfg.ratios[i+1]))
                           * rdm_pkg::MID_PROD_W'(a_m_reg);
        end
    end

    always_comb
    begin
        lhs     = rdm_pkg::CMP_W'(b_p_reg) << rdm_pkg::LHS_SHIFT;
        n_gears = rdm_pkg::gears_in_use(cfg.gear_count);
        for (int i = 0; i < NMID; i++)
        begin
            gt[i] = lhs > rdm_pkg::rev_scale(b_mp_reg[i]);
        end
        c_next.gear   = n_gears;
        c_next.mph_fd = b_m_reg;
        for (int i = NMID - 1; i >= 0; i--)
        begin
            if ((i + 1 < int'(n_gears)) && gt[i])
            begin
                c_next.gear = rdm_pkg::GEAR_W'(i + 1);
            end
        end
        if (b_mz_reg)
        begin
            c_next.gear = rdm_pkg::GEAR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
            begin
                a_v_reg <= in_valid;
            end
            if (b_rdy)
            begin
                b_v_reg <= a_v_reg;
            end
            if (c_rdy)
            begin
                c_v_reg <= b_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && in_valid)
        begin
            a_p_reg  <= a_p_next;
            a_m_reg  <= a_m_next;
            a_mz_reg <= a_mz_next;
        end
        if (b_rdy && a_v_reg)
        begin
            b_p_reg  <= a_p_reg;
            b_m_reg  <= a_m_reg;
            b_mz_reg <= a_mz_reg;
            for (int i = 0; i < NMID; i++)
            begin
                b_mp_reg[i] <= b_mp_next[i];
            end
        end
        if (c_rdy && b_v_reg)
        begin
            c_reg <= c_next;
        end
    end

endmodule

/* rtl/rdm_target_mul.sv */
module rdm_target_mul
(
    input  logic          clk,
    input  logic          rst_n,
    input  rdm_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  rdm_pkg::est_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rdm_pkg::div_t out_data
);

    logic d_v_reg, e_v_reg;
    logic d_rdy, e_rdy;

    logic [rdm_pkg::TGT_PROD_W-1:0] d_prod_reg, d_prod_next;
    logic [rdm_pkg::GEAR_W-1:0]     d_gear_reg;
    logic                           d_down_reg, d_down_next;

    logic [rdm_pkg::GEAR_W-1:0] gm2;
    logic [rdm_pkg::CMP_W-1:0]  scaled;
    logic [rdm_pkg::DIVD_W-1:0] dividend;
    logic [rdm_pkg::DIVD_W-1:0] limit;

    rdm_pkg::div_t e_reg, e_next;

    assign e_rdy    = !e_v_reg || out_ready;
    assign d_rdy    = !d_v_reg || e_rdy;
    assign in_ready = d_rdy;

    assign out_valid = e_v_reg;
    assign out_data  = e_reg;

    always_comb
    begin
        gm2         = in_data.gear - rdm_pkg::GEAR_W'(2);
        d_down_next = (in_data.gear >= rdm_pkg::GEAR_W'(2)) && (cfg.circ != '0);
        d_prod_next = rdm_pkg::TGT_PROD_W'(in_data.mph_fd)
                      * rdm_pkg::TGT_PROD_W'(cfg.ratios[gm2[rdm_pkg::GIDX_W-1:0]]);
    end

    always_comb
    begin
        scaled      = rdm_pkg::rev_scale(rdm_pkg::MID_PROD_W'(d_prod_reg));
        dividend    = scaled[rdm_pkg::NUM_SHIFT +: rdm_pkg::DIVD_W];
        limit       = rdm_pkg::DIVD_W'(cfg.circ) << rdm_pkg::RPM_W;
        e_next.gear = d_gear_reg;
        e_next.ok   = d_down_reg && (dividend < limit);
        e_next.rem  = dividend[rdm_pkg::REM_W-1:0];
        e_next.quo  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else
        begin
            if (d_rdy)
            begin
                d_v_reg <= in_valid;
            end
            if (e_rdy)
            begin
                e_v_reg <= d_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_rdy && in_valid)
        begin
            d_prod_reg <= d_prod_next;
            d_gear_reg <= in_data.gear;
            d_down_reg <= d_down_next;
        end
        if (e_rdy && d_v_reg)
        begin
            e_reg <= e_next;
        end
    end

endmodule

/* rtl/rdm_divider.sv */
module rdm_divider
(
    input  logic          clk,
    input  logic          rst_n,
    input  rdm_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  rdm_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rdm_pkg::div_t out_data
);

    localparam int NST = rdm_pkg::RPM_W;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;
    logic [NST:0]   src_v;

    rdm_pkg::div_t d_reg  [NST];
    rdm_pkg::div_t d_next [NST];
    rdm_pkg::div_t src_d  [NST+1];

    logic [rdm_pkg::REM_W-1:0] trial [NST];

    always_comb
    begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        src_v[0] = in_valid;
        src_d[0] = in_data;
        for (int k = 0; k < NST; k++)
        begin
            src_v[k+1] = v_reg[k];
            src_d[k+1] = d_reg[k];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = src_v[NST];
    assign out_data  = src_d[NST];

    // stage k resolves quotient bit NST-1-k
    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            trial[k]  = rdm_pkg::REM_W'(cfg.circ) << (NST - 1 - k);
            d_next[k] = src_d[k];
            if (src_d[k].rem >= trial[k])
            begin
                d_next[k].rem            = src_d[k].rem - trial[k];
                d_next[k].quo[NST-1-k]   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= src_v[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
        begin
            if (rdy[k] && src_v[k])
            begin
                d_reg[k] <= d_next[k];
            end
        end
    end

endmodule

/* rtl/downshift_rev_match_core.sv */
// Rev-match core: each word of speed (mph) and engine rpm yields the gear now engaged
// and the engine rpm the next lower gear needs at that road speed, flagged valid only
// when a downshift exists and the rpm lies within min_rpm..max_rpm. One word is taken
// every cycle unless stalled. It has three stages of gear estimate by exact
// cross-multiplication, two stages of target product, fourteen stages of restoring
// division by the wheel circumference, one bit each, and the output register. A stall
// at the output holds only the stages behind it; empty stages still fill. Configuration
// writes are taken at any time, one per cycle; that they take effect only on words
// accepted after all earlier results are delivered is the user's task, not the block's.
module downshift_rev_match_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] speed_mph, [21:8] engine_rpm
    input  logic [rdm_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] current_gear, [17:4] target_rpm, [18] target_valid
    output logic [rdm_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rdm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rdm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PAD_W = rdm_pkg::M_TDATA_W - rdm_pkg::GEAR_W - rdm_pkg::RPM_W - 1;

    rdm_pkg::cfg_t cfg_reg, cfg_next;

    logic          est_valid, est_ready;
    rdm_pkg::est_t est_data;
    logic          mul_valid, mul_ready;
    rdm_pkg::div_t mul_data;
    logic          div_valid, div_ready;
    rdm_pkg::div_t div_data;

    logic                        out_v_reg;
    logic [rdm_pkg::GEAR_W-1:0]  gear_reg;
    logic [rdm_pkg::RPM_W-1:0]   tgt_reg, tgt_next;
    logic                        tv_reg, tv_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (rdm_pkg::cfg_idx_t'(cfg_index))
                rdm_pkg::CFG_FINAL_DRIVE:
                    cfg_next.final_drive = cfg_data[rdm_pkg::FD_W-1:0];
                rdm_pkg::CFG_CIRCUMFERENCE:
                    cfg_next.circ = cfg_data[rdm_pkg::CIRC_W-1:0];
                rdm_pkg::CFG_MIN_RPM:
                    cfg_next.min_rpm = cfg_data[rdm_pkg::RPM_W-1:0];
                rdm_pkg::CFG_MAX_RPM:
                    cfg_next.max_rpm = cfg_data[rdm_pkg::RPM_W-1:0];
                rdm_pkg::CFG_GEAR_COUNT:
                    cfg_next.gear_count = cfg_data[rdm_pkg::GEAR_W-1:0];
                rdm_pkg::CFG_RATIOS_LOW:
                    cfg_next.ratios[rdm_pkg::GEARS_PER_WORD-1:0] = cfg_data;
                rdm_pkg::CFG_RATIOS_HIGH:
                    cfg_next.ratios[rdm_pkg::MAX_GEARS-1:rdm_pkg::GEARS_PER_WORD] = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.final_drive <= rdm_pkg::FD_RESET;
            cfg_reg.circ        <= rdm_pkg::CIRC_RESET;
            cfg_reg.min_rpm     <= rdm_pkg::MIN_RESET;
            cfg_reg.max_rpm     <= rdm_pkg::MAX_RESET;
            cfg_reg.gear_count  <= rdm_pkg::GC_RESET;
            cfg_reg.ratios      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rdm_gear_est u_est
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mph    (s_tdata[rdm_pkg::MPH_W-1:0]),
        .in_rpm    (s_tdata[rdm_pkg::MPH_W +: rdm_pkg::RPM_W]),
        .out_valid (est_valid),
        .out_ready (est_ready),
        .out_data  (est_data)
    );

    rdm_target_mul u_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (est_valid),
        .in_ready  (est_ready),
        .in_data   (est_data),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_data  (mul_data)
    );

    rdm_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_data   (mul_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    assign div_ready = !out_v_reg || m_tready;

    always_comb
    begin
        tv_next  = div_data.ok && (div_data.quo >= cfg_reg.min_rpm)
                   && (div_data.quo <= cfg_reg.max_rpm);
        tgt_next = tv_next ? div_data.quo : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (div_ready)
        begin
            out_v_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_ready && div_valid)
        begin
            gear_reg <= div_data.gear;
            tgt_reg  <= tgt_next;
            tv_reg   <= tv_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {PAD_W'(0), tv_reg, tgt_reg, gear_reg};

    a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (gear_reg >= rdm_pkg::GEAR_W'(1))
                     && (gear_reg <= rdm_pkg::gears_in_use(cfg_reg.gear_count)))
        else $error("current gear outside gears in use");

    a_valid_target: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && tv_reg) |-> (gear_reg >= rdm_pkg::GEAR_W'(2))
                                 && (tgt_reg >= cfg_reg.min_rpm)
                                 && (tgt_reg <= cfg_reg.max_rpm))
        else $error("valid target without downshift or out of range");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !tv_reg) |-> (tgt_reg == '0))
        else $error("invalid target not zero");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with no output backpressure");

endmodule
